// File: design/sample_agc_macros.svh
// Assertion macros shared by the sample AGC design files.
// Included by bare file name; needs nothing else.
`ifndef SAMPLE_AGC_MACROS_SVH
`define SAMPLE_AGC_MACROS_SVH

// Concurrent assertion on the rising clock edge, held off while reset is low.
`define SAGC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that also holds during reset.
`define SAGC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/sagc_pkg.sv
// Shared types, constants and the microcode program of the sample AGC.
// No dependencies; imported by every module of the block but sagc_isqrt.
`default_nettype none

package sagc_pkg;

  localparam int unsigned GAIN_W = 24;
  localparam int unsigned PC_W   = 4;

  localparam logic [GAIN_W-1:0] GAIN_ONE   = 24'h01_0000;
  localparam logic [15:0]       RATE_RESET = 16'd655;
  localparam logic [14:0]       REF_RESET  = 15'd16384;

  // Configuration register indexes (byte address / 4).
  typedef enum logic [1:0] {
    REG_RATE = 2'd0,
    REG_REF  = 2'd1,
    REG_MODE = 2'd2
  } reg_idx_t;

  // Datapath action of one microcode step.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_SCALE_I,
    OP_SCALE_Q,
    OP_PUSH,
    OP_SUMSQ,
    OP_AMPL_ROOT,
    OP_AMPL_ABS,
    OP_GAIN
  } op_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SI_G,
    MUL_SQ_G,
    MUL_OI_OI,
    MUL_OQ_OQ,
    MUL_DIFF_RATE
  } mul_t;

  // Condition that keeps the sequencer on the current step.
  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_NO_INPUT,
    HOLD_OUT_BUSY,
    HOLD_SQRT_BUSY
  } hold_t;

  // Condition for a jump to the step's target.
  typedef enum logic [1:0] {
    BR_NEXT,
    BR_ALWAYS,
    BR_REAL
  } br_t;

  typedef struct packed {
    op_t             op;
    mul_t            mul;
    hold_t           hold;
    br_t             br;
    logic [PC_W-1:0] target;
  } uword_t;

  // Status from the datapath that the sequencer branches on.
  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic complex_mode;
    logic sqrt_busy;
  } stat_t;

  localparam logic [PC_W-1:0] S_WAIT    = 4'd0;
  localparam logic [PC_W-1:0] S_MUL_I   = 4'd1;
  localparam logic [PC_W-1:0] S_SCALE_I = 4'd2;
  localparam logic [PC_W-1:0] S_SCALE_Q = 4'd3;
  localparam logic [PC_W-1:0] S_PUSH    = 4'd4;
  localparam logic [PC_W-1:0] S_SUMSQ   = 4'd5;
  localparam logic [PC_W-1:0] S_SQRT    = 4'd6;
  localparam logic [PC_W-1:0] S_STEP    = 4'd7;
  localparam logic [PC_W-1:0] S_REAL    = 4'd8;
  localparam logic [PC_W-1:0] S_GAIN    = 4'd9;

  // The control store: one word per step.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, mul: MUL_NONE, hold: HOLD_NONE, br: BR_NEXT, target: S_WAIT};
    case (pc)
      S_WAIT:    begin w.op = OP_ACCEPT;    w.hold = HOLD_NO_INPUT; end
      S_MUL_I:   begin w.mul = MUL_SI_G; end
      S_SCALE_I: begin w.op = OP_SCALE_I;   w.mul = MUL_SQ_G; end
      S_SCALE_Q: begin w.op = OP_SCALE_Q;   w.mul = MUL_OI_OI; end
      S_PUSH:    begin
        w.op = OP_PUSH; w.mul = MUL_OQ_OQ; w.hold = HOLD_OUT_BUSY;
        w.br = BR_REAL; w.target = S_REAL;
      end
      S_SUMSQ:   begin w.op = OP_SUMSQ; end
      S_SQRT:    begin w.op = OP_AMPL_ROOT; w.hold = HOLD_SQRT_BUSY; end
      S_STEP:    begin w.mul = MUL_DIFF_RATE; w.br = BR_ALWAYS; w.target = S_GAIN; end
      S_REAL:    begin w.op = OP_AMPL_ABS;  w.br = BR_ALWAYS; w.target = S_STEP; end
      S_GAIN:    begin w.op = OP_GAIN;      w.br = BR_ALWAYS; w.target = S_WAIT; end
      default:   begin w.br = BR_ALWAYS;    w.target = S_WAIT; end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: design/sagc_seq.sv
// Microcode sequencer of the sample AGC: step counter, control store, jumps.
// Depends on sagc_pkg.
`default_nettype none

module sagc_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire sagc_pkg::stat_t  stat,
  output sagc_pkg::uword_t    ctrl,
  output logic                fire
);
  import sagc_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            hold, take;

  always_comb begin
    ctrl = ucode(pc_r);
    case (ctrl.hold)
      HOLD_NONE:      hold = 1'b0;
      HOLD_NO_INPUT:  hold = !stat.in_valid;
      HOLD_OUT_BUSY:  hold = stat.out_busy;
      HOLD_SQRT_BUSY: hold = stat.sqrt_busy;
      default:        hold = 1'b0;
    endcase
    case (ctrl.br)
      BR_NEXT:   take = 1'b0;
      BR_ALWAYS: take = 1'b1;
      BR_REAL:   take = !stat.complex_mode;
      default:   take = 1'b0;
    endcase
    fire = !hold;
    if (hold) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/sagc_isqrt.sv
// Iterative floored square root of a 32-bit value, two root bits per cycle.
// Depends on nothing outside this file.
`default_nettype none

module sagc_isqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] radicand,
  output logic             busy,
  output logic [15:0]      root
);

  logic        busy_r, busy_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] rad_r, rad_nxt;
  logic [19:0] rem_r, rem_nxt;
  logic [15:0] root_r, root_nxt;
  logic [19:0] rem_a;
  logic [15:0] root_a;

  // One restoring step: bring in two radicand bits, try 4*root+1 for the next root bit.
  function automatic logic [35:0] sq_step(input logic [19:0] rm, input logic [15:0] rt,
                                          input logic [1:0] bits);
    logic [19:0] sh;
    logic [19:0] trial;
    sh    = {rm[17:0], bits};
    trial = {2'b00, rt, 2'b01};
    if (sh >= trial) begin
      return {sh - trial, rt[14:0], 1'b1};
    end
    return {sh, rt[14:0], 1'b0};
  endfunction

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    {rem_a, root_a} = sq_step(rem_r, root_r, rad_r[31:30]);
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      {rem_nxt, root_nxt} = sq_step(rem_a, root_a, rad_r[29:28]);
      rad_nxt = {rad_r[27:0], 4'b0000};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

`default_nettype wire

// File: design/sagc_dp.sv
// Datapath of the sample AGC: shared multiplier, output register, gain loop.
// Depends on sagc_pkg and sagc_isqrt.
`default_nettype none

module sagc_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sagc_pkg::uword_t  ctrl,
  input  wire logic              fire,
  input  wire logic signed [15:0] sample_i,
  input  wire logic signed [15:0] sample_q,
  input  wire logic [15:0]       rate,
  input  wire logic [14:0]       ref_level,
  input  wire logic              complex_mode,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic signed [15:0]     out_i,
  output logic signed [15:0]     out_q,
  output sagc_pkg::stat_t        stat_part
);
  import sagc_pkg::*;

  logic signed [15:0] si_r, sq_r, oi_r, oq_r, outi_r, outq_r;
  logic               outv_r;
  logic signed [41:0] prod_r, prod_nxt;
  logic [31:0]        acc_r;
  logic [15:0]        ampl_r;
  logic [GAIN_W-1:0]  gain_r, gain_nxt;
  logic signed [16:0] mul_a, diff;
  logic signed [24:0] mul_b;
  logic signed [41:0] gsum;
  logic signed [26:0] gstep, gnew;
  logic               sq_start, sq_busy;
  logic [15:0]        sq_root;
  logic [31:0]        radicand;

  // Round half up at bit 16 and saturate to 16 bits.
  function automatic logic signed [15:0] rnd_sat(input logic signed [41:0] p);
    logic signed [41:0] s;
    logic signed [25:0] h;
    s = p + 42'sd32768;
    h = s[41:16];
    if (h > 26'sd32767) begin
      return 16'sh7fff;
    end else if (h < -26'sd32768) begin
      return 16'sh8000;
    end
    return h[15:0];
  endfunction

  always_comb begin
    diff = $signed({2'b00, ref_level}) - $signed({1'b0, ampl_r});
    case (ctrl.mul)
      MUL_SI_G:      begin mul_a = {si_r[15], si_r}; mul_b = {1'b0, gain_r}; end
      MUL_SQ_G:      begin mul_a = {sq_r[15], sq_r}; mul_b = {1'b0, gain_r}; end
      MUL_OI_OI:     begin mul_a = {oi_r[15], oi_r}; mul_b = 25'(oi_r); end
      MUL_OQ_OQ:     begin mul_a = {oq_r[15], oq_r}; mul_b = 25'(oq_r); end
      MUL_DIFF_RATE: begin mul_a = diff;             mul_b = {9'd0, rate}; end
      default:       begin mul_a = '0;               mul_b = '0; end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // Gain step: round (diff * rate) from Q1.31 to Q8.16, then clamp the sum.
  always_comb begin
    gsum  = prod_r + 42'sd16384;
    gstep = gsum[41:15];
    gnew  = $signed({3'b000, gain_r}) + gstep;
    if (gnew[26]) begin
      gain_nxt = '0;
    end else if (gnew > 27'sd16777215) begin
      gain_nxt = '1;
    end else begin
      gain_nxt = gnew[GAIN_W-1:0];
    end
  end

  assign radicand = acc_r + prod_r[31:0];
  assign sq_start = fire && (ctrl.op == OP_SUMSQ);

  sagc_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (radicand),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_ONE;
      outv_r <= 1'b0;
    end else begin
      if (fire && ctrl.op == OP_GAIN) begin
        gain_r <= gain_nxt;
      end
      if (fire && ctrl.op == OP_PUSH) begin
        outv_r <= 1'b1;
      end else if (out_ready) begin
        outv_r <= 1'b0;
      end
    end
    if (fire && ctrl.mul != MUL_NONE) begin
      prod_r <= prod_nxt;
    end
    if (fire) begin
      case (ctrl.op)
        OP_ACCEPT:    begin si_r <= sample_i; sq_r <= sample_q; end
        OP_SCALE_I:   oi_r <= rnd_sat(prod_r);
        OP_SCALE_Q:   oq_r <= complex_mode ? rnd_sat(prod_r) : 16'sd0;
        OP_PUSH:      begin outi_r <= oi_r; outq_r <= oq_r; acc_r <= prod_r[31:0]; end
        OP_AMPL_ROOT: ampl_r <= sq_root;
        OP_AMPL_ABS:  ampl_r <= oi_r[15] ? 16'(-oi_r) : oi_r;
        default:      ;
      endcase
    end
  end

  assign out_valid = outv_r;
  assign out_i     = outi_r;
  assign out_q     = outq_r;

  always_comb begin
    stat_part              = '0;
    stat_part.out_busy     = outv_r && !out_ready;
    stat_part.sqrt_busy    = sq_busy;
    stat_part.complex_mode = complex_mode;
  end

endmodule

`default_nettype wire

// File: design/sample_agc.sv
// Feedback automatic gain control for a stream of Q1.15 samples. Every input
// transaction carries one sample (real in sample_i, or a complex I/Q pair) and
// yields exactly one output transaction holding the sample times the current
// gain, rounded half up and saturated to 16 bits; in real mode out_q is zero.
// After the output is formed, its amplitude (|I|, or floor(sqrt(I^2+Q^2)) in
// complex mode) is compared with ref_level and the Q8.16 gain moves by
// rate * (ref_level - amplitude), clamped to [0, 2^24-1]. The gain starts at
// 1.0 after reset. A small microcode sequencer steps one shared 17x25-bit
// multiplier and an iterative square root unit through each sample: accept,
// scale I and Q, push the result, form the amplitude (complex mode: square
// root, two root bits a cycle), step and update the gain, and only then take
// the next sample. A stalled output holds the push step. The result sits in an
// output register, so the block runs on with the gain update while it waits.
// Registers (APB, byte address): 0x0 rate (Q0.16, reset 655), 0x4 ref_level
// (Q1.15, reset 16384), 0x8 complex_mode (reset 0); write them only while the
// block is idle.
// Depends on sagc_pkg, sagc_seq, sagc_dp and sample_agc_macros.svh.
`default_nettype none

module sample_agc (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream. in_tdata: [15:0] sample_i, [31:16] sample_q.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,
  // Output stream. out_tdata: [15:0] out_i, [31:16] out_q.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,
  // Configuration port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import sagc_pkg::*;

`include "sample_agc_macros.svh"

  logic [15:0]        rate_r;
  logic [14:0]        ref_r;
  logic               mode_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  uword_t             ctrl;
  logic               fire;
  stat_t              stat, stat_dp;
  logic signed [15:0] out_i, out_q;

  // Configuration registers: written on the access phase of a transaction.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
      ref_r  <= REF_RESET;
      mode_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RATE: rate_r <= cfg_pwdata[15:0];
        REG_REF:  ref_r  <= cfg_pwdata[14:0];
        REG_MODE: mode_r <= cfg_pwdata[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RATE: cfg_prdata = {16'd0, rate_r};
      REG_REF:  cfg_prdata = {17'd0, ref_r};
      REG_MODE: cfg_prdata = {31'd0, mode_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // The sequencer sees the input valid alongside the datapath status.
  always_comb begin
    stat          = stat_dp;
    stat.in_valid = in_tvalid;
  end

  sagc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl),
    .fire  (fire)
  );

  sagc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .fire         (fire),
    .sample_i     (in_tdata[15:0]),
    .sample_q     (in_tdata[31:16]),
    .rate         (rate_r),
    .ref_level    (ref_r),
    .complex_mode (mode_r),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_i        (out_i),
    .out_q        (out_q),
    .stat_part    (stat_dp)
  );

  // Only the wait step takes a new sample.
  assign in_tready = (ctrl.op == OP_ACCEPT);
  assign out_tdata = {out_q, out_i};

  // After a sample is taken the block is busy with it and does not take a second one in a row.
  `SAGC_ASSERT(a_accept_busy, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready, "sample_agc: input taken twice in a row")
  // A result is only written into the output register when the slot is free or is being read out in that cycle.
  `SAGC_ASSERT(a_no_clobber, clk, rst_n, (fire && ctrl.op == OP_PUSH && out_tvalid) |-> out_tready, "sample_agc: pending result overwritten")
  // The square root unit only runs while the sequencer is parked on it.
  `SAGC_ASSERT(a_sqrt_parked, clk, rst_n, stat_dp.sqrt_busy |-> (ctrl.op == OP_AMPL_ROOT && !in_tready), "sample_agc: square root running outside its step")

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the sample_agc feedback gain control block.
// Needs sagc_pkg and the sample_agc RTL; it predicts every output transaction
// on its own and compares it with the block's stream.
`timescale 1ns / 1ps

module tb;
  import sagc_pkg::*;

  // The run is stopped here no matter what; a correct run needs far fewer.
  localparam int unsigned CYCLE_LIMIT     = 400000;
  // Cycles let pass after the last result so the gain update settles.
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned IDLE_PCT        = 19;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // Register slot past the end of the map; writes there must do nothing.
  localparam logic [1:0]  REG_SPARE       = 2'd3;

  typedef struct packed {
    logic signed [15:0] q;
    logic signed [15:0] i;
  } iq_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic [31:0] in_tdata    = '0;   // [15:0] sample_i, [31:16] sample_q
  logic        out_tready  = 1'b0;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;          // [15:0] out_i, [31:16] out_q
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Our own copy of the block's registers and gain, kept in step with it.
  logic [15:0] agc_rate = RATE_RESET;
  logic [14:0] agc_ref  = REF_RESET;
  logic        agc_cplx = 1'b0;
  logic [23:0] agc_gain = GAIN_ONE;

  // Scaled samples predicted but not yet seen on the output, oldest first.
  iq_t scaled_q[$];

  int unsigned errors    = 0;
  int unsigned cycles    = 0;
  bit          steady    = 1'b0;  // no idling on either side while set
  bit          hold_req  = 1'b0;  // asks the receiver for a long hold-off
  int unsigned hold_left = 0;

  sample_agc i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sample_agc test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Sample times Q8.16 gain, rounded half up back to Q1.15 and saturated.
  function automatic logic signed [15:0] apply_gain(input logic signed [15:0] s,
                                                    input logic [23:0] g);
    longint prod;
    prod = (longint'(s) * longint'(g) + 32768) >>> 16;
    if (prod > 32767) prod = 32767;
    else if (prod < -32768) prod = -32768;
    return prod[15:0];
  endfunction

  // Floor of the square root, found one result bit at a time from the top.
  // The sum of two squared Q1.15 values never exceeds 2^31, so 16 bits suffice.
  function automatic longint floor_root(input longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Works out the output of one accepted sample and moves the gain the way
  // the block does once that output has been formed.
  function automatic void agc_predict(input logic signed [15:0] si,
                                      input logic signed [15:0] sq);
    logic signed [15:0] oi;
    logic signed [15:0] oq;
    longint amp;
    longint step;
    longint next_gain;
    iq_t res;
    oi = apply_gain(si, agc_gain);
    oq = agc_cplx ? apply_gain(sq, agc_gain) : 16'sd0;
    if (agc_cplx) amp = floor_root(longint'(oi) * oi + longint'(oq) * oq);
    else amp = (oi < 0) ? -longint'(oi) : longint'(oi);
    step = ((longint'(agc_ref) - amp) * longint'(agc_rate) + 16384) >>> 15;
    next_gain = longint'(agc_gain) + step;
    if (next_gain < 0) next_gain = 0;
    else if (next_gain > 24'hFF_FFFF) next_gain = 24'hFF_FFFF;
    agc_gain = next_gain[23:0];
    res.i = oi;
    res.q = oq;
    scaled_q.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking. Output transactions are compared before input transactions of
  // the same edge are predicted; an output is always older than an input that
  // is accepted on the same edge, so the order does not matter here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    iq_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (scaled_q.size() == 0) begin
          errors++;
          $error("result transaction with no sample outstanding, out_tdata %h", out_tdata);
        end else begin
          want = scaled_q.pop_front();
          if (out_tdata[15:0] !== want.i) begin
            errors++;
            $error("out_i: expected %0d, actual %0d", want.i, $signed(out_tdata[15:0]));
          end
          if (out_tdata[31:16] !== want.q) begin
            errors++;
            $error("out_q: expected %0d, actual %0d", want.q, $signed(out_tdata[31:16]));
          end
        end
      end
      if (in_tvalid && in_tready) agc_predict(in_tdata[15:0], in_tdata[31:16]);
    end
  end

  // Receiver. It stalls at random, except while the steady flag is set, and
  // holds off completely for a long stretch when asked, so that the output
  // register fills and the block has to refuse new input transactions.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req  = 1'b0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks
  // ---------------------------------------------------------------------------

  // Offers one sample and returns at the edge where it is accepted. Valid only
  // drops when the sender decides to idle, so a back-to-back sample keeps it
  // high without a second assignment in the same step.
  task automatic send_sample(input logic [15:0] si, input logic [15:0] sq);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {sq, si};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stops offering, waits for every predicted result, then lets the gain
  // update of the last sample finish before anything else happens.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (scaled_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_RATE: agc_rate = value[15:0];
      REG_REF:  agc_ref  = value[14:0];
      REG_MODE: agc_cplx = value[0];
      default:  ;
    endcase
  endtask

  // Random bits above a register's width now and then, which must be dropped.
  function automatic logic [31:0] junk_above(input int unsigned bits);
    return ($urandom_range(3) == 0) ? ($urandom() << bits) : 32'd0;
  endfunction

  task automatic configure(input logic [15:0] rate, input logic [14:0] lvl,
                           input logic cplx);
    write_reg(REG_RATE, 32'(rate) | junk_above(16));
    write_reg(REG_REF,  32'(lvl)  | junk_above(15));
    write_reg(REG_MODE, 32'(cplx) | junk_above(1));
  endtask

  // Mostly full-range samples, with small values and the two extremes mixed
  // in so that the gain both climbs and falls hard.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 16'($urandom());
      5, 6:          return 16'($urandom_range(127)) - 16'd64;
      7:             return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default:       return 16'($urandom_range(4095)) - 16'd2048;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Real samples at the field extremes, with the registers as reset left them.
  task automatic test_reset_defaults();
    send_sample(16'h7FFF, 16'($urandom()));
    send_sample(16'h8000, 16'($urandom()));
    send_sample(16'h0000, 16'($urandom()));
    send_sample(16'h0001, 16'($urandom()));
    send_sample(16'hFFFF, 16'($urandom()));
    send_sample(16'h4000, 16'($urandom()));
    send_sample(16'hC000, 16'($urandom()));
  endtask

  // Complex pairs, including corners whose magnitude runs past full scale.
  task automatic test_complex_extremes();
    wait_idle();
    configure(RATE_RESET, REF_RESET, 1'b1);
    send_sample(16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h0000, 16'h8000);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'h0001);
    send_sample(16'h3039, 16'hA460);
  endtask

  // A zero target with the fastest rate drives the gain down to its floor,
  // after which every output is zero and the gain stays put.
  task automatic test_gain_floor();
    wait_idle();
    configure(16'hFFFF, 15'h0000, 1'b0);
    repeat (3) send_sample(16'h7FFF, 16'($urandom()));
    send_sample(16'h8000, 16'($urandom()));
    send_sample(16'h1234, 16'($urandom()));
  endtask

  // Silence against the highest target pushes the gain up to its ceiling; full
  // scale samples then saturate the outputs, first real, then complex. A write
  // to the unused register slot in between must leave the settings alone.
  task automatic test_gain_ceiling();
    wait_idle();
    configure(16'hFFFF, 15'h7FFF, 1'b0);
    write_reg(REG_SPARE, $urandom());
    repeat (280) send_sample(16'h0000, 16'($urandom()));
    send_sample(16'h7FFF, 16'($urandom()));
    send_sample(16'h8000, 16'($urandom()));
    send_sample(16'h1000, 16'($urandom()));
    send_sample(16'hF000, 16'($urandom()));
    wait_idle();
    write_reg(REG_MODE, 32'd1);
    send_sample(16'h7FFF, 16'h8000);
    send_sample(16'h0100, 16'hFF00);
    send_sample(16'h8000, 16'h7FFF);
  endtask

  // The receiver holds off for a long stretch while samples keep coming.
  task automatic test_backpressure();
    wait_idle();
    configure(RATE_RESET, REF_RESET, 1'b1);
    @(posedge clk);
    hold_req = 1'b1;
    repeat (24) send_sample(pick_sample(), pick_sample());
  endtask

  // A long run with no idling on either side, complex then real.
  task automatic test_steady_stream();
    wait_idle();
    configure(16'($urandom_range(4095)), 15'($urandom()), 1'b1);
    steady = 1'b1;
    repeat (75) send_sample(pick_sample(), pick_sample());
    wait_idle();
    write_reg(REG_MODE, 32'd0);
    repeat (75) send_sample(pick_sample(), pick_sample());
    wait_idle();
    steady = 1'b0;
  endtask

  // Phases of random samples, each under its own register settings. The first
  // two pin the extremes; the rest draw rate and target with a bias toward
  // their ends.
  task automatic test_random_settings();
    logic [15:0] rate;
    logic [14:0] lvl;
    logic        cplx;
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 0) begin
        rate = 16'hFFFF;
        lvl  = 15'h7FFF;
        cplx = 1'b1;
      end else if (phase == 1) begin
        rate = 16'h0000;
        lvl  = 15'h0000;
        cplx = 1'b0;
      end else begin
        case ($urandom_range(4))
          0:       rate = 16'h0000;
          1:       rate = 16'hFFFF;
          2, 3:    rate = 16'($urandom_range(2047));
          default: rate = 16'($urandom());
        endcase
        case ($urandom_range(3))
          0:       lvl = 15'h0000;
          1:       lvl = 15'h7FFF;
          default: lvl = 15'($urandom());
        endcase
        cplx = 1'($urandom_range(1));
      end
      wait_idle();
      configure(rate, lvl, cplx);
      repeat (150) send_sample(pick_sample(), pick_sample());
    end
  endtask

  // Reset is held at the start and never again.
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_complex_extremes();
    test_gain_floor();
    test_gain_ceiling();
    test_backpressure();
    test_steady_stream();
    test_random_settings();

    wait_idle();
    if (errors == 0) begin
      $display("sample_agc test passed");
    end else begin
      $display("sample_agc test failed");
    end
    $finish;
  end

endmodule
